// ===== rtl/core/nnsag_pkg.sv =====
package nnsag_pkg;

  // Default parameter values
  localparam int MaxDimDef       = 4096;
  localparam int FractionBitsDef = 10;
  localparam int AddrBitsDef     = 24;

  // Fixed field widths of the register file
  localparam int DIM_W      = 13;
  localparam int STRIDE_W   = 16;
  localparam int ORIGIN_W   = 24;
  localparam int COORD_W    = 14;  // integer part of a fine coordinate
  localparam int SUM_W      = 32;  // address adder width, covers address widths up to 32 bits
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SRC_STRIDE = 3'd4,
    REG_DST_STRIDE = 3'd5,
    REG_SRC_ORIGIN = 3'd6,
    REG_DST_ORIGIN = 3'd7
  } cfg_reg_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_pos;  // start of frame: clear position, drop active frame
    logic div_go;     // launch a ratio division
    logic div_vert;   // division operands: 0 horizontal, 1 vertical
    logic load_h;     // capture horizontal ratio
    logic load_v;     // capture vertical ratio, frame becomes active
    logic step;       // form products and advance position
    logic load_pix;   // load output register with addresses
    logic load_err;   // load output register with error status
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic dims_zero;
    logic frame_active;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/core/nnsag_div.sv =====
module nnsag_div #(
  parameter int FRACTION_BITS = nnsag_pkg::FractionBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [nnsag_pkg::DIM_W-1:0]            num_i,
  input  logic [nnsag_pkg::DIM_W-1:0]            den_i,
  output logic [FRACTION_BITS+nnsag_pkg::DIM_W-1:0] quo_o,
  output logic                                   done_o
);
  import nnsag_pkg::*;

  localparam int N      = FRACTION_BITS + DIM_W;
  localparam int CNT_W  = $clog2(N + 1);

  logic [DIM_W-1:0] rem_q, rem_d;
  logic [N-1:0]     quo_q, quo_d;
  logic [DIM_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DIM_W:0]   rem_sh;
  logic [DIM_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q, quo_q[N-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = {num_i, {FRACTION_BITS{1'b0}}};
      den_d  = den_i;
      cnt_d  = CNT_W'(N);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
      quo_d = {quo_q[N-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/nnsag_dp.sv =====
module nnsag_dp #(
  parameter int MAX_DIM       = nnsag_pkg::MaxDimDef,
  parameter int FRACTION_BITS = nnsag_pkg::FractionBitsDef,
  parameter int ADDR_BITS     = nnsag_pkg::AddrBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nnsag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nnsag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  nnsag_pkg::cmd_t                  cmd_i,
  output nnsag_pkg::sts_t                  sts_o,
  output logic [ADDR_BITS-1:0]             src_addr_o,
  output logic [ADDR_BITS-1:0]             dst_addr_o,
  output logic                             row_end_o,
  output logic                             frame_end_o,
  output logic                             status_o
);
  import nnsag_pkg::*;

  localparam int RATIO_W = FRACTION_BITS + DIM_W;
  localparam int FINE_W  = FRACTION_BITS + COORD_W;
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int CMP_W   = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
  localparam int SPROD_W = COORD_W + STRIDE_W;
  localparam int DPROD_W = CNT_W + STRIDE_W;

  // Configuration registers
  logic [DIM_W-1:0]    src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [STRIDE_W-1:0] src_stride_q, dst_stride_q;
  logic [ORIGIN_W-1:0] src_origin_q, dst_origin_q;

  // Walk state
  logic [CNT_W-1:0]   col_q, col_d, row_q, row_d;
  logic [FINE_W-1:0]  fine_x_q, fine_x_d, fine_y_q, fine_y_d;
  logic [RATIO_W-1:0] hratio_q, hratio_d, vratio_q, vratio_d;
  logic               active_q, active_d;

  // Step stage and output registers
  logic [SPROD_W-1:0] sprod_q;
  logic [DPROD_W-1:0] dprod_q;
  logic [COORD_W-1:0] sx_q;
  logic [CNT_W-1:0]   col_snap_q;
  logic               row_end_q, frame_end_q;
  logic [ADDR_BITS-1:0] src_addr_q, dst_addr_q;
  logic               row_end_out_q, frame_end_out_q, status_q;

  logic [RATIO_W-1:0] quo;
  logic               div_done;
  logic [DIM_W-1:0]   div_num, div_den;
  logic [CMP_W-1:0]   eff_w, eff_h, col_inc, row_inc;
  logic               at_row_end, at_frame_end;
  logic [SUM_W-1:0]   src_sum, dst_sum;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q      <= '0;
      src_h_q      <= '0;
      dst_w_q      <= '0;
      dst_h_q      <= '0;
      src_stride_q <= '0;
      dst_stride_q <= '0;
      src_origin_q <= '0;
      dst_origin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SRC_WIDTH:  src_w_q      <= cfg_data_i[DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_q      <= cfg_data_i[DIM_W-1:0];
        REG_DST_WIDTH:  dst_w_q      <= cfg_data_i[DIM_W-1:0];
        REG_DST_HEIGHT: dst_h_q      <= cfg_data_i[DIM_W-1:0];
        REG_SRC_STRIDE: src_stride_q <= cfg_data_i[STRIDE_W-1:0];
        REG_DST_STRIDE: dst_stride_q <= cfg_data_i[STRIDE_W-1:0];
        REG_SRC_ORIGIN: src_origin_q <= cfg_data_i[ORIGIN_W-1:0];
        REG_DST_ORIGIN: dst_origin_q <= cfg_data_i[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared serial divider for both ratios
  assign div_num = cmd_i.div_vert ? src_h_q : src_w_q;
  assign div_den = cmd_i.div_vert ? dst_h_q : dst_w_q;

  nnsag_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (quo),
    .done_o (div_done)
  );

  // Clamp destination size and detect row and frame ends
  assign eff_w = (CMP_W'(dst_w_q) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(dst_w_q);
  assign eff_h = (CMP_W'(dst_h_q) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(dst_h_q);
  assign col_inc      = CMP_W'(col_q) + CMP_W'(1);
  assign row_inc      = CMP_W'(row_q) + CMP_W'(1);
  assign at_row_end   = col_inc >= eff_w;
  assign at_frame_end = at_row_end && (row_inc >= eff_h);

  // Advance the walk state
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    fine_x_d = fine_x_q;
    fine_y_d = fine_y_q;
    hratio_d = hratio_q;
    vratio_d = vratio_q;
    active_d = active_q;
    if (cmd_i.clear_pos) begin
      col_d    = '0;
      row_d    = '0;
      fine_x_d = '0;
      fine_y_d = '0;
      active_d = 1'b0;
    end
    if (cmd_i.load_h) begin
      hratio_d = quo;
    end
    if (cmd_i.load_v) begin
      vratio_d = quo;
      active_d = 1'b1;
    end
    if (cmd_i.step) begin
      if (at_row_end) begin
        col_d    = '0;
        fine_x_d = '0;
        if (at_frame_end) begin
          row_d    = '0;
          fine_y_d = '0;
          active_d = 1'b0;
        end else begin
          row_d    = row_q + CNT_W'(1);
          fine_y_d = fine_y_q + FINE_W'(vratio_q);
        end
      end else begin
        col_d    = col_q + CNT_W'(1);
        fine_x_d = fine_x_q + FINE_W'(hratio_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      fine_x_q <= '0;
      fine_y_q <= '0;
      hratio_q <= '0;
      vratio_q <= '0;
      active_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      fine_x_q <= fine_x_d;
      fine_y_q <= fine_y_d;
      hratio_q <= hratio_d;
      vratio_q <= vratio_d;
      active_q <= active_d;
    end
  end

  // Register line products and snapshot the current position
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      sprod_q     <= fine_y_q[FINE_W-1:FRACTION_BITS] * src_stride_q;
      dprod_q     <= row_q * dst_stride_q;
      sx_q        <= fine_x_q[FINE_W-1:FRACTION_BITS];
      col_snap_q  <= col_q;
      row_end_q   <= at_row_end;
      frame_end_q <= at_frame_end;
    end
  end

  // Sum addresses, wrapping at the address width
  assign src_sum = SUM_W'(src_origin_q) + SUM_W'(sprod_q) + SUM_W'(sx_q);
  assign dst_sum = SUM_W'(dst_origin_q) + SUM_W'(dprod_q) + SUM_W'(col_snap_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      src_addr_q      <= src_sum[ADDR_BITS-1:0];
      dst_addr_q      <= dst_sum[ADDR_BITS-1:0];
      row_end_out_q   <= row_end_q;
      frame_end_out_q <= frame_end_q;
      status_q        <= 1'b0;
    end else if (cmd_i.load_err) begin
      src_addr_q      <= '0;
      dst_addr_q      <= '0;
      row_end_out_q   <= 1'b0;
      frame_end_out_q <= 1'b0;
      status_q        <= 1'b1;
    end
  end

  assign sts_o.dims_zero    = (src_w_q == '0) || (src_h_q == '0) ||
                              (dst_w_q == '0) || (dst_h_q == '0);
  assign sts_o.frame_active = active_q;
  assign sts_o.div_done     = div_done;

  assign src_addr_o  = src_addr_q;
  assign dst_addr_o  = dst_addr_q;
  assign row_end_o   = row_end_out_q;
  assign frame_end_o = frame_end_out_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/core/nnsag_ctrl.sv =====
module nnsag_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            restart_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  nnsag_pkg::sts_t sts_i,
  output nnsag_pkg::cmd_t cmd_o
);
  import nnsag_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV_H = 6'b000010,
    ST_DIV_V = 6'b000100,
    ST_STEP  = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_ERR   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i || !sts_i.frame_active) begin
            cmd_o.clear_pos = 1'b1;
            if (sts_i.dims_zero) begin
              state_d = ST_ERR;
            end else begin
              cmd_o.div_go = 1'b1;
              state_d      = ST_DIV_H;
            end
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_DIV_H: begin
        cmd_o.div_vert = 1'b0;
        if (sts_i.div_done) begin
          cmd_o.load_h   = 1'b1;
          cmd_o.div_go   = 1'b1;
          cmd_o.div_vert = 1'b1;
          state_d        = ST_DIV_V;
        end
      end
      ST_DIV_V: begin
        if (sts_i.div_done) begin
          cmd_o.load_v = 1'b1;
          state_d      = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load_pix = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          cmd_o.load_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Set valid on load, drop it once the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_pix || cmd_o.load_err) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/nearest_neighbour_scale_addr_gen_top.sv =====
// Nearest-neighbour resize address generator for one grey plane.
// Program the eight window registers through the cfg channel while the block
// is idle; cfg_ready_o is always high. Each item on the slave stream is one
// destination-pixel tick (tdata bit 0: restart). Each tick returns one item on
// the master stream with the source byte offset to read and the destination
// byte offset to write, tlast on the last pixel of the frame, and tuser
// carrying the end-of-row mark and the error status.
// A tick with restart set, or any tick while no frame runs, starts a frame:
// the two step ratios are computed one after the other by one shared
// bit-serial divider, then the first pixel runs the steps of a tick below.
// Within a frame a tick runs the position step with line multiplies, then
// the address add into the output register; the controller takes the next
// item only once the previous one is loaded, so it handles one item at a
// time. A zero window dimension at frame start gives status 1.
// Reset clears the configuration registers and the walk; the next tick starts a frame.
// If the receiver stalls, the result waits in the output register; one more
// item is taken and computed, then the controller holds until the register
// drains.
module nearest_neighbour_scale_addr_gen_top #(
  parameter int MAX_DIM       = nnsag_pkg::MaxDimDef,
  parameter int FRACTION_BITS = nnsag_pkg::FractionBitsDef,
  parameter int ADDR_BITS     = nnsag_pkg::AddrBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [0] restart
  // master stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // source_addr, then dest_addr, each ADDR_BITS wide, zero padded to bytes
  output logic [((2*ADDR_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o,  // frame_end
  output logic [1:0]                       m_axis_tuser_o,  // [0] row_end, [1] status
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nnsag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nnsag_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nnsag_pkg::*;

  localparam int TDATA_W = ((2 * ADDR_BITS + 7) / 8) * 8;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [ADDR_BITS-1:0] src_addr, dst_addr;
  logic                 row_end, frame_end, status;

  assign cfg_ready_o = 1'b1;

  nnsag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .restart_i  (s_axis_tdata_i[0]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nnsag_dp #(
    .MAX_DIM      (MAX_DIM),
    .FRACTION_BITS(FRACTION_BITS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .src_addr_o  (src_addr),
    .dst_addr_o  (dst_addr),
    .row_end_o   (row_end),
    .frame_end_o (frame_end),
    .status_o    (status)
  );

  // Pack result fields onto the master stream
  assign m_axis_tdata_o = TDATA_W'({dst_addr, src_addr});
  assign m_axis_tlast_o = frame_end;
  assign m_axis_tuser_o = {status, row_end};

endmodule
